>>> hw/rtl/hpack_pkg.sv
`timescale 1ns / 1ps

package hpack_pkg;

    localparam int unsigned CodeW  = 30;
    localparam int unsigned LenW   = 5;
    localparam int unsigned OBits  = 8;
    localparam int unsigned FreeW  = 4;
    localparam int unsigned RomDepth = 256;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_PACK,
        ST_PAD
    } state_t;

    // code table: code in the low 30 bits, length above
    function automatic logic [CodeW+LenW-1:0] rom_entry(input logic [7:0] sym);
        logic [CodeW-1:0] c;
        logic [LenW-1:0]  l;
        case (sym)
            8'd0: begin c = 30'h1ff8; l = 5'd13; end
            8'd1: begin c = 30'h7fffd8; l = 5'd23; end
            8'd2: begin c = 30'hfffffe2; l = 5'd28; end
            8'd3: begin c = 30'hfffffe3; l = 5'd28; end
            8'd4: begin c = 30'hfffffe4; l = 5'd28; end
            8'd5: begin c = 30'hfffffe5; l = 5'd28; end
            8'd6: begin c = 30'hfffffe6; l = 5'd28; end
            8'd7: begin c = 30'hfffffe7; l = 5'd28; end
            8'd8: begin c = 30'hfffffe8; l = 5'd28; end
            8'd9: begin c = 30'hffffea; l = 5'd24; end
            8'd10: begin c = 30'h3ffffffc; l = 5'd30; end
            8'd11: begin c = 30'hfffffe9; l = 5'd28; end
            8'd12: begin c = 30'hfffffea; l = 5'd28; end
            8'd13: begin c = 30'h3ffffffd; l = 5'd30; end
            8'd14: begin c = 30'hfffffeb; l = 5'd28; end
            8'd15: begin c = 30'hfffffec; l = 5'd28; end
            8'd16: begin c = 30'hfffffed; l = 5'd28; end
            8'd17: begin c = 30'hfffffee; l = 5'd28; end
            8'd18: begin c = 30'hfffffef; l = 5'd28; end
            8'd19: begin c = 30'hffffff0; l = 5'd28; end
            8'd20: begin c = 30'hffffff1; l = 5'd28; end
            8'd21: begin c = 30'hffffff2; l = 5'd28; end
            8'd22: begin c = 30'h3ffffffe; l = 5'd30; end
            8'd23: begin c = 30'hffffff3; l = 5'd28; end
            8'd24: begin c = 30'hffffff4; l = 5'd28; end
            8'd25: begin c = 30'hffffff5; l = 5'd28; end
            8'd26: begin c = 30'hffffff6; l = 5'd28; end
            8'd27: begin c = 30'hffffff7; l = 5'd28; end
            8'd28: begin c = 30'hffffff8; l = 5'd28; end
            8'd29: begin c = 30'hffffff9; l = 5'd28; end
            8'd30: begin c = 30'hffffffa; l = 5'd28; end
            8'd31: begin c = 30'hffffffb; l = 5'd28; end
            8'd32: begin c = 30'h14; l = 5'd6; end
            8'd33: begin c = 30'h3f8; l = 5'd10; end
            8'd34: begin c = 30'h3f9; l = 5'd10; end
            8'd35: begin c = 30'hffa; l = 5'd12; end
            8'd36: begin c = 30'h1ff9; l = 5'd13; end
            8'd37: begin c = 30'h15; l = 5'd6; end
            8'd38: begin c = 30'hf8; l = 5'd8; end
            8'd39: begin c = 30'h7fa; l = 5'd11; end
            8'd40: begin c = 30'h3fa; l = 5'd10; end
            8'd41: begin c = 30'h3fb; l = 5'd10; end
            8'd42: begin c = 30'hf9; l = 5'd8; end
            8'd43: begin c = 30'h7fb; l = 5'd11; end
            8'd44: begin c = 30'hfa; l = 5'd8; end
            8'd45: begin c = 30'h16; l = 5'd6; end
            8'd46: begin c = 30'h17; l = 5'd6; end
            8'd47: begin c = 30'h18; l = 5'd6; end
            8'd48: begin c = 30'h0; l = 5'd5; end
            8'd49: begin c = 30'h1; l = 5'd5; end
            8'd50: begin c = 30'h2; l = 5'd5; end
            8'd51: begin c = 30'h19; l = 5'd6; end
            8'd52: begin c = 30'h1a; l = 5'd6; end
            8'd53: begin c = 30'h1b; l = 5'd6; end
            8'd54: begin c = 30'h1c; l = 5'd6; end
            8'd55: begin c = 30'h1d; l = 5'd6; end
            8'd56: begin c = 30'h1e; l = 5'd6; end
            8'd57: begin c = 30'h1f; l = 5'd6; end
            8'd58: begin c = 30'h5c; l = 5'd7; end
            8'd59: begin c = 30'hfb; l = 5'd8; end
            8'd60: begin c = 30'h7ffc; l = 5'd15; end
            8'd61: begin c = 30'h20; l = 5'd6; end
            8'd62: begin c = 30'hffb; l = 5'd12; end
            8'd63: begin c = 30'h3fc; l = 5'd10; end
            8'd64: begin c = 30'h1ffa; l = 5'd13; end
            8'd65: begin c = 30'h21; l = 5'd6; end
            8'd66: begin c = 30'h5d; l = 5'd7; end
            8'd67: begin c = 30'h5e; l = 5'd7; end
            8'd68: begin c = 30'h5f; l = 5'd7; end
            8'd69: begin c = 30'h60; l = 5'd7; end
            8'd70: begin c = 30'h61; l = 5'd7; end
            8'd71: begin c = 30'h62; l = 5'd7; end
            8'd72: begin c = 30'h63; l = 5'd7; end
            8'd73: begin c = 30'h64; l = 5'd7; end
            8'd74: begin c = 30'h65; l = 5'd7; end
            8'd75: begin c = 30'h66; l = 5'd7; end
            8'd76: begin c = 30'h67; l = 5'd7; end
            8'd77: begin c = 30'h68; l = 5'd7; end
            8'd78: begin c = 30'h69; l = 5'd7; end
            8'd79: begin c = 30'h6a; l = 5'd7; end
            8'd80: begin c = 30'h6b; l = 5'd7; end
            8'd81: begin c = 30'h6c; l = 5'd7; end
            8'd82: begin c = 30'h6d; l = 5'd7; end
            8'd83: begin c = 30'h6e; l = 5'd7; end
            8'd84: begin c = 30'h6f; l = 5'd7; end
            8'd85: begin c = 30'h70; l = 5'd7; end
            8'd86: begin c = 30'h71; l = 5'd7; end
            8'd87: begin c = 30'h72; l = 5'd7; end
            8'd88: begin c = 30'hfc; l = 5'd8; end
            8'd89: begin c = 30'h73; l = 5'd7; end
            8'd90: begin c = 30'hfd; l = 5'd8; end
            8'd91: begin c = 30'h1ffb; l = 5'd13; end
            8'd92: begin c = 30'h7fff0; l = 5'd19; end
            8'd93: begin c = 30'h1ffc; l = 5'd13; end
            8'd94: begin c = 30'h3ffc; l = 5'd14; end
            8'd95: begin c = 30'h22; l = 5'd6; end
            8'd96: begin c = 30'h7ffd; l = 5'd15; end
            8'd97: begin c = 30'h3; l = 5'd5; end
            8'd98: begin c = 30'h23; l = 5'd6; end
            8'd99: begin c = 30'h4; l = 5'd5; end
            8'd100: begin c = 30'h24; l = 5'd6; end
            8'd101: begin c = 30'h5; l = 5'd5; end
            8'd102: begin c = 30'h25; l = 5'd6; end
            8'd103: begin c = 30'h26; l = 5'd6; end
            8'd104: begin c = 30'h27; l = 5'd6; end
            8'd105: begin c = 30'h6; l = 5'd5; end
            8'd106: begin c = 30'h74; l = 5'd7; end
            8'd107: begin c = 30'h75; l = 5'd7; end
            8'd108: begin c = 30'h28; l = 5'd6; end
            8'd109: begin c = 30'h29; l = 5'd6; end
            8'd110: begin c = 30'h2a; l = 5'd6; end
            8'd111: begin c = 30'h7; l = 5'd5; end
            8'd112: begin c = 30'h2b; l = 5'd6; end
            8'd113: begin c = 30'h76; l = 5'd7; end
            8'd114: begin c = 30'h2c; l = 5'd6; end
            8'd115: begin c = 30'h8; l = 5'd5; end
            8'd116: begin c = 30'h9; l = 5'd5; end
            8'd117: begin c = 30'h2d; l = 5'd6; end
            8'd118: begin c = 30'h77; l = 5'd7; end
            8'd119: begin c = 30'h78; l = 5'd7; end
            8'd120: begin c = 30'h79; l = 5'd7; end
            8'd121: begin c = 30'h7a; l = 5'd7; end
            8'd122: begin c = 30'h7b; l = 5'd7; end
            8'd123: begin c = 30'h7ffe; l = 5'd15; end
            8'd124: begin c = 30'h7fc; l = 5'd11; end
            8'd125: begin c = 30'h3ffd; l = 5'd14; end
            8'd126: begin c = 30'h1ffd; l = 5'd13; end
            8'd127: begin c = 30'hffffffc; l = 5'd28; end
            8'd128: begin c = 30'hfffe6; l = 5'd20; end
            8'd129: begin c = 30'h3fffd2; l = 5'd22; end
            8'd130: begin c = 30'hfffe7; l = 5'd20; end
            8'd131: begin c = 30'hfffe8; l = 5'd20; end
            8'd132: begin c = 30'h3fffd3; l = 5'd22; end
            8'd133: begin c = 30'h3fffd4; l = 5'd22; end
            8'd134: begin c = 30'h3fffd5; l = 5'd22; end
            8'd135: begin c = 30'h7fffd9; l = 5'd23; end
            8'd136: begin c = 30'h3fffd6; l = 5'd22; end
            8'd137: begin c = 30'h7fffda; l = 5'd23; end
            8'd138: begin c = 30'h7fffdb; l = 5'd23; end
            8'd139: begin c = 30'h7fffdc; l = 5'd23; end
            8'd140: begin c = 30'h7fffdd; l = 5'd23; end
            8'd141: begin c = 30'h7fffde; l = 5'd23; end
            8'd142: begin c = 30'hffffeb; l = 5'd24; end
            8'd143: begin c = 30'h7fffdf; l = 5'd23; end
            8'd144: begin c = 30'hffffec; l = 5'd24; end
            8'd145: begin c = 30'hffffed; l = 5'd24; end
            8'd146: begin c = 30'h3fffd7; l = 5'd22; end
            8'd147: begin c = 30'h7fffe0; l = 5'd23; end
            8'd148: begin c = 30'hffffee; l = 5'd24; end
            8'd149: begin c = 30'h7fffe1; l = 5'd23; end
            8'd150: begin c = 30'h7fffe2; l = 5'd23; end
            8'd151: begin c = 30'h7fffe3; l = 5'd23; end
            8'd152: begin c = 30'h7fffe4; l = 5'd23; end
            8'd153: begin c = 30'h1fffdc; l = 5'd21; end
            8'd154: begin c = 30'h3fffd8; l = 5'd22; end
            8'd155: begin c = 30'h7fffe5; l = 5'd23; end
            8'd156: begin c = 30'h3fffd9; l = 5'd22; end
            8'd157: begin c = 30'h7fffe6; l = 5'd23; end
            8'd158: begin c = 30'h7fffe7; l = 5'd23; end
            8'd159: begin c = 30'hffffef; l = 5'd24; end
            8'd160: begin c = 30'h3fffda; l = 5'd22; end
            8'd161: begin c = 30'h1fffdd; l = 5'd21; end
            8'd162: begin c = 30'hfffe9; l = 5'd20; end
            8'd163: begin c = 30'h3fffdb; l = 5'd22; end
            8'd164: begin c = 30'h3fffdc; l = 5'd22; end
            8'd165: begin c = 30'h7fffe8; l = 5'd23; end
            8'd166: begin c = 30'h7fffe9; l = 5'd23; end
            8'd167: begin c = 30'h1fffde; l = 5'd21; end
            8'd168: begin c = 30'h7fffea; l = 5'd23; end
            8'd169: begin c = 30'h3fffdd; l = 5'd22; end
            8'd170: begin c = 30'h3fffde; l = 5'd22; end
            8'd171: begin c = 30'hfffff0; l = 5'd24; end
            8'd172: begin c = 30'h1fffdf; l = 5'd21; end
            8'd173: begin c = 30'h3fffdf; l = 5'd22; end
            8'd174: begin c = 30'h7fffeb; l = 5'd23; end
            8'd175: begin c = 30'h7fffec; l = 5'd23; end
            8'd176: begin c = 30'h1fffe0; l = 5'd21; end
            8'd177: begin c = 30'h1fffe1; l = 5'd21; end
            8'd178: begin c = 30'h3fffe0; l = 5'd22; end
            8'd179: begin c = 30'h1fffe2; l = 5'd21; end
            8'd180: begin c = 30'h7fffed; l = 5'd23; end
            8'd181: begin c = 30'h3fffe1; l = 5'd22; end
            8'd182: begin c = 30'h7fffee; l = 5'd23; end
            8'd183: begin c = 30'h7fffef; l = 5'd23; end
            8'd184: begin c = 30'hfffea; l = 5'd20; end
            8'd185: begin c = 30'h3fffe2; l = 5'd22; end
            8'd186: begin c = 30'h3fffe3; l = 5'd22; end
            8'd187: begin c = 30'h3fffe4; l = 5'd22; end
            8'd188: begin c = 30'h7ffff0; l = 5'd23; end
            8'd189: begin c = 30'h3fffe5; l = 5'd22; end
            8'd190: begin c = 30'h3fffe6; l = 5'd22; end
            8'd191: begin c = 30'h7ffff1; l = 5'd23; end
            8'd192: begin c = 30'h3ffffe0; l = 5'd26; end
            8'd193: begin c = 30'h3ffffe1; l = 5'd26; end
            8'd194: begin c = 30'hfffeb; l = 5'd20; end
            8'd195: begin c = 30'h7fff1; l = 5'd19; end
            8'd196: begin c = 30'h3fffe7; l = 5'd22; end
            8'd197: begin c = 30'h7ffff2; l = 5'd23; end
            8'd198: begin c = 30'h3fffe8; l = 5'd22; end
            8'd199: begin c = 30'h1ffffec; l = 5'd25; end
            8'd200: begin c = 30'h3ffffe2; l = 5'd26; end
            8'd201: begin c = 30'h3ffffe3; l = 5'd26; end
            8'd202: begin c = 30'h3ffffe4; l = 5'd26; end
            8'd203: begin c = 30'h7ffffde; l = 5'd27; end
            8'd204: begin c = 30'h7ffffdf; l = 5'd27; end
            8'd205: begin c = 30'h3ffffe5; l = 5'd26; end
            8'd206: begin c = 30'hfffff1; l = 5'd24; end
            8'd207: begin c = 30'h1ffffed; l = 5'd25; end
            8'd208: begin c = 30'h7fff2; l = 5'd19; end
            8'd209: begin c = 30'h1fffe3; l = 5'd21; end
            8'd210: begin c = 30'h3ffffe6; l = 5'd26; end
            8'd211: begin c = 30'h7ffffe0; l = 5'd27; end
            8'd212: begin c = 30'h7ffffe1; l = 5'd27; end
            8'd213: begin c = 30'h3ffffe7; l = 5'd26; end
            8'd214: begin c = 30'h7ffffe2; l = 5'd27; end
            8'd215: begin c = 30'hfffff2; l = 5'd24; end
            8'd216: begin c = 30'h1fffe4; l = 5'd21; end
            8'd217: begin c = 30'h1fffe5; l = 5'd21; end
            8'd218: begin c = 30'h3ffffe8; l = 5'd26; end
            8'd219: begin c = 30'h3ffffe9; l = 5'd26; end
            8'd220: begin c = 30'hffffffd; l = 5'd28; end
            8'd221: begin c = 30'h7ffffe3; l = 5'd27; end
            8'd222: begin c = 30'h7ffffe4; l = 5'd27; end
            8'd223: begin c = 30'h7ffffe5; l = 5'd27; end
            8'd224: begin c = 30'hfffec; l = 5'd20; end
            8'd225: begin c = 30'hfffff3; l = 5'd24; end
            8'd226: begin c = 30'hfffed; l = 5'd20; end
            8'd227: begin c = 30'h1fffe6; l = 5'd21; end
            8'd228: begin c = 30'h3fffe9; l = 5'd22; end
            8'd229: begin c = 30'h1fffe7; l = 5'd21; end
            8'd230: begin c = 30'h1fffe8; l = 5'd21; end
            8'd231: begin c = 30'h7ffff3; l = 5'd23; end
            8'd232: begin c = 30'h3fffea; l = 5'd22; end
            8'd233: begin c = 30'h3fffeb; l = 5'd22; end
            8'd234: begin c = 30'h1ffffee; l = 5'd25; end
            8'd235: begin c = 30'h1ffffef; l = 5'd25; end
            8'd236: begin c = 30'hfffff4; l = 5'd24; end
            8'd237: begin c = 30'hfffff5; l = 5'd24; end
            8'd238: begin c = 30'h3ffffea; l = 5'd26; end
            8'd239: begin c = 30'h7ffff4; l = 5'd23; end
            8'd240: begin c = 30'h3ffffeb; l = 5'd26; end
            8'd241: begin c = 30'h7ffffe6; l = 5'd27; end
            8'd242: begin c = 30'h3ffffec; l = 5'd26; end
            8'd243: begin c = 30'h3ffffed; l = 5'd26; end
            8'd244: begin c = 30'h7ffffe7; l = 5'd27; end
            8'd245: begin c = 30'h7ffffe8; l = 5'd27; end
            8'd246: begin c = 30'h7ffffe9; l = 5'd27; end
            8'd247: begin c = 30'h7ffffea; l = 5'd27; end
            8'd248: begin c = 30'h7ffffeb; l = 5'd27; end
            8'd249: begin c = 30'hffffffe; l = 5'd28; end
            8'd250: begin c = 30'h7ffffec; l = 5'd27; end
            8'd251: begin c = 30'h7ffffed; l = 5'd27; end
            8'd252: begin c = 30'h7ffffee; l = 5'd27; end
            8'd253: begin c = 30'h7ffffef; l = 5'd27; end
            8'd254: begin c = 30'h7fffff0; l = 5'd27; end
            default: begin c = 30'h3ffffee; l = 5'd26; end
        endcase
        return {l, c};
    endfunction

endpackage

>>> hw/rtl/hpack_huffman_encoder_unit.sv
`timescale 1ns / 1ps
// first octet: registered after the rom read, the lookup state and the first pack step, when that step fills it
// per byte: idle, lookup, one pack step per octet touched, and a pad step when a string ends mid-octet;
//   a new byte is taken only in the idle state, once the last one is packed
// one packing step per cycle, except that a pack or pad step waits
//   while the one-octet output register holds an octet not yet taken
// reset: synchronous active-low aresetn clears control, open octet empty (8 free bits)
module hpack_huffman_encoder_unit (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] symbol
    input  logic       s_tlast,   // end_of_string
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] octet
    output logic       m_tlast    // final_octet
);

    localparam int unsigned EntW = hpack_pkg::CodeW + hpack_pkg::LenW;

    // code rom, synchronous read
    logic [EntW-1:0] rom_mem [hpack_pkg::RomDepth];
    logic [EntW-1:0] rom_rd_reg;

    always_ff @(posedge aclk) begin
        rom_rd_reg <= rom_mem[s_tdata];
    end

    for (genvar i = 0; i < hpack_pkg::RomDepth; i++) begin : g_rom
        assign rom_mem[i] = hpack_pkg::rom_entry(8'(i));
    end

    hpack_pkg::state_t state_reg, state_next;
    logic [hpack_pkg::CodeW-1:0] code_reg, code_next;
    logic [hpack_pkg::LenW-1:0]  bits_reg, bits_next;
    logic                        last_reg, last_next;
    logic [7:0]                  part_reg, part_next;
    logic [hpack_pkg::FreeW-1:0] free_reg, free_next;
    logic                        mv_reg, mv_next;
    logic [7:0]                  md_reg, md_next;
    logic                        ml_reg, ml_next;

    logic                        out_free;
    logic [hpack_pkg::FreeW-1:0] take;
    logic [7:0]                  chunk;
    logic [hpack_pkg::LenW-1:0]  rem;
    logic [7:0]                  merged;
    logic [hpack_pkg::FreeW-1:0] free_after;

    assign out_free = !mv_reg || m_tready;
    assign s_tready = (state_reg == hpack_pkg::ST_IDLE);
    assign m_tvalid = mv_reg;
    assign m_tdata  = md_reg;
    assign m_tlast  = ml_reg;

    // one packing step: move up to free bits of the code into the open octet
    always_comb begin
        if ({1'b0, bits_reg} > {2'b0, free_reg}) begin
            take = free_reg;
        end else begin
            take = bits_reg[hpack_pkg::FreeW-1:0];
        end
        rem        = bits_reg - {1'b0, take};
        free_after = free_reg - take;
        chunk      = 8'((code_reg >> rem) & ((30'd1 << take) - 30'd1));
        merged     = part_reg | 8'(chunk << free_after);
    end

    always_comb begin
        state_next = state_reg;
        code_next  = code_reg;
        bits_next  = bits_reg;
        last_next  = last_reg;
        part_next  = part_reg;
        free_next  = free_reg;
        mv_next    = mv_reg && !m_tready;
        md_next    = md_reg;
        ml_next    = ml_reg;
        case (state_reg)
            hpack_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    last_next  = s_tlast;
                    state_next = hpack_pkg::ST_LOOKUP;
                end
            end
            hpack_pkg::ST_LOOKUP: begin
                code_next  = rom_rd_reg[hpack_pkg::CodeW-1:0];
                bits_next  = rom_rd_reg[EntW-1:hpack_pkg::CodeW];
                state_next = hpack_pkg::ST_PACK;
            end
            hpack_pkg::ST_PACK: begin
                if (out_free) begin
                    bits_next = rem;
                    if (free_after == '0) begin
                        // octet full: emit, final if string ends exactly here
                        mv_next   = 1'b1;
                        md_next   = merged;
                        ml_next   = last_reg && (rem == '0);
                        part_next = '0;
                        free_next = 4'(hpack_pkg::OBits);
                    end else begin
                        part_next = merged;
                        free_next = free_after;
                    end
                    if (rem == '0) begin
                        if (last_reg && free_after != '0) begin
                            state_next = hpack_pkg::ST_PAD;
                        end else begin
                            state_next = hpack_pkg::ST_IDLE;
                        end
                    end
                end
            end
            hpack_pkg::ST_PAD: begin
                if (out_free) begin
                    mv_next    = 1'b1;
                    md_next    = part_reg | 8'((9'd1 << free_reg) - 9'd1);
                    ml_next    = 1'b1;
                    part_next  = '0;
                    free_next  = 4'(hpack_pkg::OBits);
                    state_next = hpack_pkg::ST_IDLE;
                end
            end
            default: state_next = hpack_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= hpack_pkg::ST_IDLE;
            part_reg  <= '0;
            free_reg  <= 4'(hpack_pkg::OBits);
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            part_reg  <= part_next;
            free_reg  <= free_next;
            mv_reg    <= mv_next;
        end
    end

    always_ff @(posedge aclk) begin
        code_reg <= code_next;
        bits_reg <= bits_next;
        last_reg <= last_next;
        md_reg   <= md_next;
        ml_reg   <= ml_next;
    end

`ifndef SYNTHESIS
    // open octet never has zero or more than eight free bits
    a_free_range: assert property (@(posedge aclk) disable iff (!aresetn)
        free_reg != '0 && free_reg <= 4'(hpack_pkg::OBits))
        else $error("free bit count out of range");

    // after a final octet is taken the packer is empty
    a_final_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (mv_reg && m_tready && ml_reg && state_reg == hpack_pkg::ST_IDLE)
        |-> free_reg == 4'(hpack_pkg::OBits))
        else $error("packer not empty after final octet");

    // no request taken while packing
    a_no_take_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == hpack_pkg::ST_PACK) |-> !s_tready)
        else $error("request taken while packing");

    // pad state always has a partly filled octet
    a_pad_partial: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == hpack_pkg::ST_PAD) |-> free_reg < 4'(hpack_pkg::OBits))
        else $error("pad with empty octet");
`endif

endmodule
